/* rtl/svpwm_pkg.sv */
package svpwm_pkg;

    localparam int unsigned VEC_W     = 16;   // alpha/beta command width
    localparam int unsigned DUTY_W    = 15;   // compare value width
    localparam int unsigned SEC_W     = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned PADDR_W   = 3;

    // serial multiplier: signed multiplicand times unsigned multiplier
    localparam int unsigned MCAND_W   = 18;
    localparam int unsigned MPLR_W    = 16;
    localparam int unsigned PROD_W    = MCAND_W + MPLR_W;
    localparam int unsigned MUL_STEPS = MPLR_W;

    // serial divider: quotient is known to fit in QUO_W bits
    localparam int unsigned QUO_W     = 16;
    localparam int unsigned DIVS_W    = 18;
    localparam int unsigned DIVD_W    = 33;
    localparam int unsigned DIV_STEPS = QUO_W;

    localparam int unsigned CNT_W     = $clog2(MUL_STEPS + 1);

    localparam int unsigned TIME_W    = 17;   // clamped active time
    localparam int unsigned PROJ_W    = 18;   // X, Y, Z and py, pz
    localparam int unsigned Q_SHIFT   = 15;
    localparam int unsigned SUM_W     = 33;   // Q30 sign sums

    localparam logic [MPLR_W-1:0] SQRT3_HALF_Q15 = 16'd28378;
    localparam int unsigned       HALF_SHIFT     = 14;   // 1/2 in Q15 is 2^14

    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd4250;
    localparam logic [CFG_W-1:0] GAIN_RST   = 16'd32768;

    typedef enum logic [0:0] {
        REG_PERIOD = 1'b0,
        REG_GAIN   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SEL,
        ST_MUL3,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef logic [SEC_W-1:0] t_sector;

    localparam t_sector SEC_NONE = 3'd0;
    localparam t_sector SEC_1    = 3'd1;
    localparam t_sector SEC_2    = 3'd2;
    localparam t_sector SEC_3    = 3'd3;
    localparam t_sector SEC_4    = 3'd4;
    localparam t_sector SEC_5    = 3'd5;
    localparam t_sector SEC_6    = 3'd6;

    typedef struct packed {
        logic [TIME_W-1:0] t1;
        logic [TIME_W-1:0] t2;
    } t_times;

    typedef struct packed {
        logic [DUTY_W-1:0] a;
        logic [DUTY_W-1:0] b;
        logic [DUTY_W-1:0] c;
    } t_duty;

    // code bits: {vc > 0, vb > 0, beta > 0}
    function automatic t_sector sector_of_code(input logic [2:0] code);
        t_sector sec;
        unique case (code)
            3'd1:    sec = SEC_2;
            3'd2:    sec = SEC_6;
            3'd3:    sec = SEC_1;
            3'd4:    sec = SEC_4;
            3'd5:    sec = SEC_3;
            3'd6:    sec = SEC_5;
            default: sec = SEC_NONE;
        endcase
        return sec;
    endfunction

    function automatic logic [TIME_W-1:0] clamp_time(input logic signed [PROJ_W:0] v);
        logic [TIME_W-1:0] t;
        if (v[PROJ_W]) begin
            t = '0;
        end else begin
            t = v[TIME_W-1:0];
        end
        return t;
    endfunction

    function automatic t_times pick_times(
        input t_sector                  sec,
        input logic signed [PROJ_W-1:0] x,
        input logic signed [PROJ_W-1:0] y,
        input logic signed [PROJ_W-1:0] z
    );
        logic signed [PROJ_W:0] xe;
        logic signed [PROJ_W:0] ye;
        logic signed [PROJ_W:0] ze;
        t_times r;
        xe = {x[PROJ_W-1], x};
        ye = {y[PROJ_W-1], y};
        ze = {z[PROJ_W-1], z};
        unique case (sec)
            SEC_2: begin
                r.t1 = clamp_time(ze);
                r.t2 = clamp_time(ye);
            end
            SEC_6: begin
                r.t1 = clamp_time(ye);
                r.t2 = clamp_time(-xe);
            end
            SEC_4: begin
                r.t1 = clamp_time(-xe);
                r.t2 = clamp_time(ze);
            end
            SEC_3: begin
                r.t1 = clamp_time(xe);
                r.t2 = clamp_time(-ye);
            end
            SEC_5: begin
                r.t1 = clamp_time(-ye);
                r.t2 = clamp_time(-ze);
            end
            default: begin
                r.t1 = clamp_time(-ze);
                r.t2 = clamp_time(xe);
            end
        endcase
        return r;
    endfunction

    function automatic t_duty order_duty(
        input t_sector           sec,
        input logic [DUTY_W-1:0] ta,
        input logic [DUTY_W-1:0] tb,
        input logic [DUTY_W-1:0] tc
    );
        t_duty d;
        unique case (sec)
            SEC_2:   d = '{a: tb, b: ta, c: tc};
            SEC_6:   d = '{a: ta, b: tc, c: tb};
            SEC_4:   d = '{a: tc, b: tb, c: ta};
            SEC_3:   d = '{a: tc, b: ta, c: tb};
            SEC_5:   d = '{a: tb, b: tc, c: ta};
            default: d = '{a: ta, b: tb, c: tc};
        endcase
        return d;
    endfunction

endpackage

/* rtl/svpwm_in_if.sv */
interface svpwm_in_if import svpwm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] u_alpha;
    logic signed [VEC_W-1:0] u_beta;

    modport source (output valid, output u_alpha, output u_beta, input ready);
    modport sink   (input valid, input u_alpha, input u_beta, output ready);
endinterface

/* rtl/svpwm_out_if.sv */
interface svpwm_out_if import svpwm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [SEC_W-1:0]  sector;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output sector, input ready);
    modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                    input sector, output ready);
endinterface

/* rtl/svpwm_mul.sv */
module svpwm_mul import svpwm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [MCAND_W-1:0] i_mcand,
    input  logic [MPLR_W-1:0]         i_mplr,
    output logic                      o_busy,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic [CNT_W-1:0]          r_cnt;
    logic signed [MCAND_W-1:0] r_mcand;
    logic signed [MCAND_W-1:0] r_hi;
    logic [MPLR_W-1:0]         r_lo;
    logic signed [MCAND_W:0]   n_sum;

    assign o_busy = (r_cnt != '0);
    assign o_prod = {r_hi, r_lo};

    // one multiplier bit per cycle, LSB first; product shifts right into r_lo
    always_comb begin
        n_sum = {r_hi[MCAND_W-1], r_hi};
        if (r_lo[0]) begin
            n_sum = n_sum + {r_mcand[MCAND_W-1], r_mcand};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(MUL_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplr;
        end else if (o_busy) begin
            r_hi <= n_sum[MCAND_W:1];
            r_lo <= {n_sum[0], r_lo[MPLR_W-1:1]};
        end
    end

endmodule

/* rtl/svpwm_div.sv */
module svpwm_div import svpwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [QUO_W-1:0]  o_quot
);

    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_div;
    logic [DIVS_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_dq;    // dividend bits shift out, quotient bits shift in
    logic [DIVS_W:0]   n_trial;
    logic              n_ge;

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_dq;

    // restoring division; the caller guarantees the upper dividend bits are below the divisor
    always_comb begin
        n_trial = {r_rem, r_dq[QUO_W-1]};
        n_ge    = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= DIVS_W'(i_dividend[DIVD_W-1:QUO_W]);
            r_dq  <= i_dividend[QUO_W-1:0];
        end else if (o_busy) begin
            if (n_ge) begin
                r_rem <= DIVS_W'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[DIVS_W-1:0];
            end
            r_dq <= {r_dq[QUO_W-2:0], n_ge};
        end
    end

endmodule

/* rtl/svpwm_sector_duty.sv */
// A vector is taken in ST_IDLE and runs ST_MUL1, ST_MUL2, ST_SEL, then ST_MUL3
// and ST_DIV when the active times are scaled down, and ST_FIN, which waits for
// a free output register. No new vector is taken until the result is registered.
// The work is done by 16-step serial multipliers (up to three rounds) and dividers.
// Reset (i_rst_n low, synchronous): period 4250, gain 32768, last sector one,
// no result pending.
module svpwm_sector_duty import svpwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    svpwm_in_if.sink           i_vec,
    svpwm_out_if.source        o_duty
);

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]         r_period;
    logic [CFG_W-1:0]         r_gain;
    t_sector                  r_sector;
    logic signed [VEC_W-1:0]  r_b;
    logic signed [PROJ_W-1:0] r_x;
    logic [TIME_W-1:0]        r_t1;
    logic [TIME_W-1:0]        r_t2;
    logic [DIVS_W-1:0]        r_sum;

    logic              r_out_valid;
    logic [DUTY_W-1:0] r_duty_a;
    logic [DUTY_W-1:0] r_duty_b;
    logic [DUTY_W-1:0] r_duty_c;
    t_sector           r_out_sector;

    logic                      mul0_start, mul1_start, div_start;
    logic                      mul0_busy, mul1_busy, div0_busy, div1_busy;
    logic signed [MCAND_W-1:0] mul0_a, mul1_a;
    logic [MPLR_W-1:0]         mul0_m, mul1_m;
    logic signed [PROD_W-1:0]  mul0_prod, mul1_prod;
    logic [QUO_W-1:0]          div0_q, div1_q;

    logic                      ld_proj, ld_times, ld_sum, ld_quot, ld_out;
    logic                      accept, out_free, cfg_wr;
    logic signed [SUM_W-1:0]   ka, hb, sy, sz;
    logic signed [PROJ_W-1:0]  py, pz;
    logic [2:0]                code;
    t_sector                   sec_raw, n_sector;
    t_times                    times;
    logic [DIVS_W-1:0]         sum;
    logic                      scale;
    logic [DIVS_W-1:0]         diff;
    logic [DUTY_W-1:0]         ta, tb, tc;
    t_duty                     duty;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[PADDR_W-1]))
            REG_PERIOD: prdata = PDATA_W'(r_period);
            REG_GAIN:   prdata = PDATA_W'(r_gain);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_gain   <= GAIN_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[PADDR_W-1]))
                REG_PERIOD: r_period <= pwdata[CFG_W-1:0];
                REG_GAIN:   r_gain   <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // handshakes
    assign i_vec.ready   = (r_state == ST_IDLE);
    assign accept        = i_vec.valid && i_vec.ready;
    assign out_free      = !r_out_valid || o_duty.ready;
    assign o_duty.valid  = r_out_valid;
    assign o_duty.duty_a = r_duty_a;
    assign o_duty.duty_b = r_duty_b;
    assign o_duty.duty_c = r_duty_c;
    assign o_duty.sector = r_out_sector;

    // projections and sector signs, Q30
    always_comb begin
        ka       = mul0_prod[SUM_W-1:0];
        hb       = {{(SUM_W - VEC_W - HALF_SHIFT){r_b[VEC_W-1]}}, r_b, HALF_SHIFT'(0)};
        sy       = ka + hb;
        sz       = hb - ka;
        py       = sy[SUM_W-1:Q_SHIFT];
        pz       = sz[SUM_W-1:Q_SHIFT];
        // vb > 0 is sz < 0, vc > 0 is sy < 0
        code     = {sy[SUM_W-1], sz[SUM_W-1], (!r_b[VEC_W-1] && (r_b != '0))};
        sec_raw  = sector_of_code(code);
        n_sector = (sec_raw == SEC_NONE) ? r_sector : sec_raw;
    end

    always_comb begin
        times = pick_times(r_sector, r_x,
                           mul0_prod[Q_SHIFT+PROJ_W-1:Q_SHIFT],
                           mul1_prod[Q_SHIFT+PROJ_W-1:Q_SHIFT]);
        sum   = {1'b0, r_t1} + {1'b0, r_t2};
        scale = (sum > DIVS_W'(r_period));
        diff  = DIVS_W'(r_period) - {1'b0, r_t1} - {1'b0, r_t2};
        ta    = diff[DUTY_W+1:2];
        tb    = ta + r_t1[DUTY_W:1];
        tc    = tb + r_t2[DUTY_W:1];
        duty  = order_duty(r_sector, ta, tb, tc);
    end

    // operand selection for the shared serial units
    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                mul0_a = MCAND_W'(i_vec.u_alpha);
                mul0_m = SQRT3_HALF_Q15;
                mul1_a = MCAND_W'(i_vec.u_beta);
                mul1_m = r_gain;
            end
            ST_MUL1: begin
                mul0_a = py;
                mul0_m = r_gain;
                mul1_a = pz;
                mul1_m = r_gain;
            end
            default: begin
                mul0_a = {1'b0, r_t1};
                mul0_m = r_period;
                mul1_a = {1'b0, r_t2};
                mul1_m = r_period;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        mul0_start = 1'b0;
        mul1_start = 1'b0;
        div_start  = 1'b0;
        ld_proj    = 1'b0;
        ld_times   = 1'b0;
        ld_sum     = 1'b0;
        ld_quot    = 1'b0;
        ld_out     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    mul0_start = 1'b1;
                    mul1_start = 1'b1;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (!mul0_busy) begin
                    ld_proj    = 1'b1;
                    mul0_start = 1'b1;
                    mul1_start = 1'b1;
                    n_state    = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (!mul0_busy) begin
                    ld_times = 1'b1;
                    n_state  = ST_SEL;
                end
            end
            ST_SEL: begin
                if (scale) begin
                    ld_sum     = 1'b1;
                    mul0_start = 1'b1;
                    mul1_start = 1'b1;
                    n_state    = ST_MUL3;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL3: begin
                if (!mul0_busy) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div0_busy && !div1_busy) begin
                    ld_quot = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sector    <= SEC_1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_proj) begin
                r_sector <= n_sector;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_duty.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b <= i_vec.u_beta;
        end
        if (ld_proj) begin
            r_x <= mul1_prod[Q_SHIFT+PROJ_W-1:Q_SHIFT];
        end
        if (ld_times) begin
            r_t1 <= times.t1;
            r_t2 <= times.t2;
        end
        if (ld_sum) begin
            r_sum <= sum;
        end
        if (ld_quot) begin
            r_t1 <= TIME_W'(div0_q);
            r_t2 <= TIME_W'(div1_q);
        end
        if (ld_out) begin
            r_duty_a     <= duty.a;
            r_duty_b     <= duty.b;
            r_duty_c     <= duty.c;
            r_out_sector <= r_sector;
        end
    end

    svpwm_mul u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul0_start),
        .i_mcand (mul0_a),
        .i_mplr  (mul0_m),
        .o_busy  (mul0_busy),
        .o_prod  (mul0_prod)
    );

    svpwm_mul u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul1_start),
        .i_mcand (mul1_a),
        .i_mplr  (mul1_m),
        .o_busy  (mul1_busy),
        .o_prod  (mul1_prod)
    );

    // the multipliers always start together and run in lockstep, so mul1_busy never gates
    svpwm_div u_div0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start && !mul1_busy),
        .i_dividend (mul0_prod[DIVD_W-1:0]),
        .i_divisor  (r_sum),
        .o_busy     (div0_busy),
        .o_quot     (div0_q)
    );

    svpwm_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start && !mul1_busy),
        .i_dividend (mul1_prod[DIVD_W-1:0]),
        .i_divisor  (r_sum),
        .o_busy     (div1_busy),
        .o_quot     (div1_q)
    );

endmodule
